### rtl/core/battery_voltage_monitor_unit_assert.svh
// Assertion macros for the battery voltage monitor.
`ifndef BATTERY_VOLTAGE_MONITOR_UNIT_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_UNIT_ASSERT_SVH

// Checked outside reset.
`define BVM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bvm assertion failed");

// Checked on every edge, reset included.
`define BVM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bvm assertion failed");

`endif

### rtl/core/bvm_pkg.sv
// Types, constants and the charge ladder of the battery voltage monitor.
package bvm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int FACTOR_W   = 16;
  localparam int CELLS_W    = 3;
  localparam int DIV_NUM_W  = 30;
  localparam int DIV_DEN_W  = 12;
  localparam int DIV_STEP_W = 5;
  localparam int LADDER_N   = 16;
  localparam int TRIM       = 2;
  localparam int FILT_DIV   = 10;
  // reciprocal of the filter divisor, exact for sums below 2^20
  localparam int FILT_SH    = 24;
  localparam int FILT_MUL   = ((1 << FILT_SH) + FILT_DIV - 1) / FILT_DIV;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd2000;
  localparam logic [CELLS_W-1:0]  CELLS_RST  = 3'd1;

  localparam logic [12:0] LADDER_MV [LADDER_N] = '{
    13'd4100, 13'd3960, 13'd3860, 13'd3780, 13'd3700, 13'd3670, 13'd3620, 13'd3590,
    13'd3510, 13'd3480, 13'd3300, 13'd3250, 13'd3150, 13'd3100, 13'd2950, 13'd2900
  };
  localparam logic [PCT_W-1:0] LADDER_PCT [LADDER_N] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30,
    7'd20, 7'd15, 7'd10, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] ref_sample;
    logic [SAMPLE_W-1:0] bat_sample;
  } bvm_req_t;

  typedef struct packed {
    logic [MV_W-1:0]  filtered_mv;
    logic [MV_W-1:0]  raw_mv;
    logic [PCT_W-1:0] charge_pct;
    logic             ref_zero;
  } bvm_res_t;

  typedef struct packed {
    logic load;
    logic shift;
  } bvm_cell_ctrl_t;

  function automatic logic [PCT_W-1:0] charge_pct(input logic [MV_W-1:0] mv,
                                                 input logic [CELLS_W-1:0] cells);
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  thr;
    pct = '0;
    for (int k = LADDER_N - 1; k >= 0; k--) begin
      thr = MV_W'({3'b000, LADDER_MV[k]} * {13'd0, cells});
      if (mv >= thr) pct = LADDER_PCT[k];
    end
    return pct;
  endfunction

endpackage

### rtl/core/bvm_sort_cell.sv
// One cell of the insertion-sort chain: holds one sample, takes new or neighbour data.
module bvm_sort_cell (
  input  logic                           clk_i,
  input  bvm_pkg::bvm_cell_ctrl_t        ctrl_i,
  input  logic                           occ_i,
  input  logic                           lt_left_i,
  input  logic [bvm_pkg::SAMPLE_W-1:0]   left_val_i,
  input  logic [bvm_pkg::SAMPLE_W-1:0]   right_val_i,
  input  logic [bvm_pkg::SAMPLE_W-1:0]   new_val_i,
  output logic [bvm_pkg::SAMPLE_W-1:0]   val_o,
  output logic                           lt_o
);
  import bvm_pkg::*;

  logic [SAMPLE_W-1:0] val_q, val_d;

  assign lt_o  = occ_i && (val_q <= new_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.load) begin
      if (!lt_o) begin
        val_d = lt_left_i ? new_val_i : left_val_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### rtl/core/bvm_divider.sv
// Restoring divider, one quotient bit per cycle.
module bvm_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bvm_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [bvm_pkg::DIV_DEN_W-1:0] den_i,
  output logic                          done_o,
  output logic [bvm_pkg::DIV_NUM_W-1:0] quot_o
);
  import bvm_pkg::*;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [DIV_DEN_W-1:0]  rem_q, rem_d;
  logic [DIV_DEN_W-1:0]  den_q, den_d;
  logic [DIV_NUM_W-1:0]  acc_q, acc_d;
  logic [DIV_DEN_W:0]    rem_sh;
  logic                  ge;

  assign rem_sh = {rem_q, acc_q[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = acc_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    acc_d  = acc_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = den_i;
      acc_d  = num_i;
    end else if (run_q) begin
      rem_d = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      acc_d = {acc_q[DIV_NUM_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == DIV_STEP_W'(DIV_NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    acc_q <= acc_d;
  end

endmodule

### rtl/core/battery_voltage_monitor_unit.sv
// Battery voltage monitor: trimmed-mean ADC filter, lag filter and charge ladder.
//
// Channel  | Handshake                              | Payload
// request  | start / busy, taken when start & !busy | req_i (bvm_req_t)
// result   | res_valid_o, one cycle, no back-pressure | res_o (bvm_res_t)
// config   | APB write, psel & penable & pwrite      | pwdata, paddr[2] selects register
//
// A request that does not complete a set only stores its samples; busy stays low.
// The request that completes a set starts unloading the sort chain (ST_UNLOAD), then the
// trimmed means (ST_MEAN), the zero check (ST_CHECK), the multiply and one divider pass, then
// the lag filter (ST_FGO, skipped for the first set) and the result strobe (ST_EMIT); a zero
// reference skips the multiply and the divider. busy drops after the strobe.
// Reset is asynchronous, active low; the sort chain itself is not reset.
module battery_voltage_monitor_unit #(
  parameter int SAMPLES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bvm_pkg::bvm_req_t req_i,
  output logic              res_valid_o,
  output bvm_pkg::bvm_res_t res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bvm_pkg::*;

  localparam int CntW    = $clog2(SAMPLES);
  localparam int SumW    = SAMPLE_W + $clog2(SAMPLES);
  localparam int MeanDiv = SAMPLES - 2 * TRIM;
  localparam int MeanSh  = SumW + $clog2(MeanDiv);
  localparam int MeanMul = ((1 << MeanSh) + MeanDiv - 1) / MeanDiv;
  localparam int MeanPW  = MeanSh + SAMPLE_W;
  localparam int FiltPW  = FILT_SH + MV_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UNLOAD = 4'd1;
  localparam logic [3:0] ST_MEAN   = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_VGO    = 4'd5;
  localparam logic [3:0] ST_VWAIT  = 4'd6;
  localparam logic [3:0] ST_FGO    = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     k_q, k_d;
  logic [SumW-1:0]     sum_r_q, sum_r_d, sum_b_q, sum_b_d;
  logic [SAMPLE_W-1:0] ref_mean_q, ref_mean_d, bat_mean_q, bat_mean_d;
  logic [27:0]         prod_q, prod_d;
  logic [MV_W-1:0]     raw_q, raw_d, filt_q, filt_d;
  logic                zero_q, zero_d, has_q, has_d;
  logic [FACTOR_W-1:0] factor_q;
  logic [CELLS_W-1:0]  cells_q;

  logic                accept, cfg_wr;
  bvm_cell_ctrl_t      cell_ctrl;
  logic [SAMPLE_W-1:0] rv [SAMPLES];
  logic [SAMPLE_W-1:0] bv [SAMPLES];
  logic                rlt [SAMPLES];
  logic                blt [SAMPLES];
  logic                occ [SAMPLES];

  logic                div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic [30:0]         prod5;
  logic [19:0]         fsum;
  logic [MeanPW-1:0]   mean_r_prod, mean_b_prod;
  logic [FiltPW-1:0]   filt_prod;

  assign accept = start && !busy;
  assign busy   = state_q != ST_IDLE;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {29'd0, cells_q} : {16'd0, factor_q};

  assign cell_ctrl.load  = accept;
  assign cell_ctrl.shift = state_q == ST_UNLOAD;

  for (genvar i = 0; i < SAMPLES; i++) begin : g_chain
    logic                lt_l_r, lt_l_b;
    logic [SAMPLE_W-1:0] left_r, left_b, right_r, right_b;
    assign occ[i] = cnt_q > CntW'(i);
    if (i == 0) begin : g_first
      assign lt_l_r = 1'b1;
      assign lt_l_b = 1'b1;
      assign left_r = '0;
      assign left_b = '0;
    end else begin : g_mid
      assign lt_l_r = rlt[i-1];
      assign lt_l_b = blt[i-1];
      assign left_r = rv[i-1];
      assign left_b = bv[i-1];
    end
    if (i == SAMPLES - 1) begin : g_last
      assign right_r = '0;
      assign right_b = '0;
    end else begin : g_inner
      assign right_r = rv[i+1];
      assign right_b = bv[i+1];
    end
    bvm_sort_cell u_ref_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occ_i       (occ[i]),
      .lt_left_i   (lt_l_r),
      .left_val_i  (left_r),
      .right_val_i (right_r),
      .new_val_i   (req_i.ref_sample),
      .val_o       (rv[i]),
      .lt_o        (rlt[i])
    );
    bvm_sort_cell u_bat_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occ_i       (occ[i]),
      .lt_left_i   (lt_l_b),
      .left_val_i  (left_b),
      .right_val_i (right_b),
      .new_val_i   (req_i.bat_sample),
      .val_o       (bv[i]),
      .lt_o        (blt[i])
    );
  end

  bvm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign prod5 = {1'b0, prod_q, 2'b00} + 31'(prod_q);
  assign fsum  = {1'b0, filt_q, 3'b000} + {3'b000, raw_q, 1'b0};

  // constant divisions by reciprocal multiplication
  assign mean_r_prod = MeanPW'(sum_r_q) * MeanPW'(MeanMul);
  assign mean_b_prod = MeanPW'(sum_b_q) * MeanPW'(MeanMul);
  assign filt_prod   = FiltPW'(fsum) * FiltPW'(FILT_MUL);

  assign div_start = state_q == ST_VGO;
  assign div_num   = prod5[30:1];
  assign div_den   = ref_mean_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    sum_r_d    = sum_r_q;
    sum_b_d    = sum_b_q;
    ref_mean_d = ref_mean_q;
    bat_mean_d = bat_mean_q;
    prod_d     = prod_q;
    raw_d      = raw_q;
    filt_d     = filt_q;
    zero_d     = zero_q;
    has_d      = has_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q == CntW'(SAMPLES - 1)) begin
            cnt_d   = '0;
            k_d     = '0;
            sum_r_d = '0;
            sum_b_d = '0;
            state_d = ST_UNLOAD;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_UNLOAD: begin
        if (k_q >= CntW'(TRIM) && k_q <= CntW'(SAMPLES - 1 - TRIM)) begin
          sum_r_d = sum_r_q + SumW'(rv[0]);
          sum_b_d = sum_b_q + SumW'(bv[0]);
        end
        k_d = k_q + 1'b1;
        if (k_q == CntW'(SAMPLES - 1)) state_d = ST_MEAN;
      end
      ST_MEAN: begin
        ref_mean_d = mean_r_prod[MeanSh +: SAMPLE_W];
        bat_mean_d = mean_b_prod[MeanSh +: SAMPLE_W];
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        zero_d = ref_mean_q == '0;
        if (ref_mean_q == '0) begin
          raw_d   = '1;
          state_d = has_q ? ST_FGO : ST_EMIT;
          if (!has_q) begin
            filt_d = '1;
            has_d  = 1'b1;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = 28'(bat_mean_q) * 28'(factor_q);
        state_d = ST_VGO;
      end
      ST_VGO:   state_d = ST_VWAIT;
      ST_VWAIT: begin
        if (div_done) begin
          raw_d = (|div_quot[DIV_NUM_W-1:MV_W]) ? '1 : div_quot[MV_W-1:0];
          if (!has_q) begin
            filt_d  = (|div_quot[DIV_NUM_W-1:MV_W]) ? '1 : div_quot[MV_W-1:0];
            has_d   = 1'b1;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_FGO;
          end
        end
      end
      ST_FGO: begin
        filt_d  = filt_prod[FILT_SH +: MV_W];
        state_d = ST_EMIT;
      end
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      k_q      <= '0;
      filt_q   <= '0;
      has_q    <= 1'b0;
      factor_q <= FACTOR_RST;
      cells_q  <= CELLS_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      filt_q  <= filt_d;
      has_q   <= has_d;
      if (cfg_wr) begin
        if (paddr[2]) cells_q <= pwdata[CELLS_W-1:0];
        else          factor_q <= pwdata[FACTOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_r_q    <= sum_r_d;
    sum_b_q    <= sum_b_d;
    ref_mean_q <= ref_mean_d;
    bat_mean_q <= bat_mean_d;
    prod_q     <= prod_d;
    raw_q      <= raw_d;
    zero_q     <= zero_d;
  end

  assign res_valid_o       = state_q == ST_EMIT;
  assign res_o.filtered_mv = filt_q;
  assign res_o.raw_mv      = raw_q;
  assign res_o.charge_pct  = charge_pct(filt_q, cells_q);
  assign res_o.ref_zero    = zero_q;

endmodule

### rtl/core/bvm_checker.sv
// Port-level checks of the battery voltage monitor, bound to the top level.
`include "battery_voltage_monitor_unit_assert.svh"

module bvm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input bvm_pkg::bvm_req_t req_i,
  input logic              res_valid_o,
  input bvm_pkg::bvm_res_t res_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);
  import bvm_pkg::*;

  `BVM_ASSERT(a_res_while_busy, clk_i, rst_ni, res_valid_o |-> busy)
  `BVM_ASSERT(a_res_single, clk_i, rst_ni, res_valid_o |=> !res_valid_o && !busy)
  `BVM_ASSERT(a_pct_range, clk_i, rst_ni, res_valid_o |-> res_o.charge_pct <= 7'd100)
  `BVM_ASSERT(a_zero_sat, clk_i, rst_ni, (res_valid_o && res_o.ref_zero) |-> res_o.raw_mv == 16'hFFFF)
  `BVM_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind battery_voltage_monitor_unit bvm_checker u_bvm_checker (.*);

### test/battery_voltage_monitor_unit_test.sv
// Self-checking bench for the battery voltage monitor: sample sets in, filtered readings checked.
`timescale 1ns / 100ps

module battery_voltage_monitor_unit_test;
  import bvm_pkg::*;

  localparam int SET_LEN        = 16;
  localparam int ITEM_TARGET    = 1450;
  localparam int QUIET_TAIL     = 160;
  localparam int SETTLE_CYCLES  = 220;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LADDER_STEPS   = 16;

  localparam logic [2:0] REG_DIVIDER = 3'd0;
  localparam logic [2:0] REG_CELLS   = 3'd4;

  localparam int unsigned THRESH_MV [LADDER_STEPS] = '{
    4100, 3960, 3860, 3780, 3700, 3670, 3620, 3590,
    3510, 3480, 3300, 3250, 3150, 3100, 2950, 2900
  };
  localparam int unsigned LEVEL_PCT [LADDER_STEPS] = '{
    100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 4, 3, 2, 1
  };

  typedef enum int {
    SET_TRACKING,
    SET_NOISE,
    SET_ZERO_REF,
    SET_OVERFLOW,
    SET_RAILS
  } set_kind_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  bvm_req_t    req_i   = '0;
  logic        res_valid_o;
  bvm_res_t    res_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [SAMPLE_W-1:0] ref_hist [SET_LEN];
  logic [SAMPLE_W-1:0] bat_hist [SET_LEN];
  int unsigned         fill_count = 0;
  logic [MV_W-1:0]     lag_mv     = '0;
  bit                  lag_loaded = 1'b0;
  logic [FACTOR_W-1:0] cfg_factor = FACTOR_RST;
  logic [CELLS_W-1:0]  cfg_cells  = CELLS_RST;

  bvm_res_t    pending_readings [$];
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b0;
  int unsigned unit_mv     = 3700;

  battery_voltage_monitor_unit #(
    .SAMPLES(SET_LEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  function automatic int unsigned trimmed_average(bit pick_bat);
    logic [SAMPLE_W-1:0] v [SET_LEN];
    logic [SAMPLE_W-1:0] key;
    int                  j;
    int unsigned         acc;
    for (int i = 0; i < SET_LEN; i++) v[i] = pick_bat ? bat_hist[i] : ref_hist[i];
    for (int i = 1; i < SET_LEN; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    acc = 0;
    for (int i = TRIM; i < SET_LEN - TRIM; i++) acc += v[i];
    return acc / (SET_LEN - 2 * TRIM);
  endfunction

  // Stores one accepted request; on a full set works out the reading it causes.
  task automatic absorb_sample(bvm_req_t s);
    int unsigned       ref_avg;
    int unsigned       bat_avg;
    int unsigned       raw;
    logic [63:0]       quotient;
    bit                hit;
    bvm_res_t          r;
    ref_hist[fill_count] = s.ref_sample;
    bat_hist[fill_count] = s.bat_sample;
    fill_count++;
    if (fill_count == SET_LEN) begin
      fill_count = 0;
      ref_avg = trimmed_average(1'b0);
      bat_avg = trimmed_average(1'b1);
      r = '0;
      r.ref_zero = (ref_avg == 0);
      if (r.ref_zero) begin
        raw = 65535;
      end else begin
        quotient = 64'(bat_avg) * 64'(cfg_factor) * 64'd5 / 64'd2 / 64'(ref_avg);
        raw = (quotient > 64'd65535) ? 32'd65535 : 32'(quotient);
      end
      if (!lag_loaded) begin
        lag_mv = MV_W'(raw);
        lag_loaded = 1'b1;
      end else begin
        lag_mv = MV_W'((32'(lag_mv) * 32'd8 + raw * 32'd2) / 32'd10);
      end
      r.filtered_mv = lag_mv;
      r.raw_mv = MV_W'(raw);
      r.charge_pct = '0;
      hit = 1'b0;
      for (int k = 0; k < LADDER_STEPS; k++) begin
        if (!hit && 32'(lag_mv) >= THRESH_MV[k] * 32'(cfg_cells)) begin
          r.charge_pct = PCT_W'(LEVEL_PCT[k]);
          hit = 1'b1;
        end
      end
      pending_readings.push_back(r);
    end
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_register(logic [2:0] addr, output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes only once the block is idle, then reads the register back.
  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    logic [31:0] want;
    logic [31:0] readback;
    wait_for_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_DIVIDER) cfg_factor = data[FACTOR_W-1:0];
    else if (addr == REG_CELLS) cfg_cells = data[CELLS_W-1:0];
    want = (addr == REG_DIVIDER) ? 32'(cfg_factor) : 32'(cfg_cells);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    read_register(addr, readback);
    if (readback !== want) report_mismatch("register readback", want, readback);
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] ref_v, logic [SAMPLE_W-1:0] bat_v);
    bvm_req_t s;
    s.ref_sample = ref_v;
    s.bat_sample = bat_v;
    start <= 1'b1;
    req_i <= s;
    do @(posedge clk_i); while (busy);
    absorb_sample(s);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_flat_set(logic [SAMPLE_W-1:0] ref_v, logic [SAMPLE_W-1:0] bat_v);
    for (int i = 0; i < SET_LEN; i++) send_sample(ref_v, bat_v);
  endtask

  function automatic logic [SAMPLE_W-1:0] clip12(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return SAMPLE_W'(v);
  endfunction

  task automatic send_set(set_kind_e kind);
    int unsigned tgt;
    int unsigned bat_base;
    int unsigned ref_base;
    logic [63:0] ratio;
    int          rv;
    int          bv;
    if ($urandom_range(0, 9) == 0) unit_mv = $urandom_range(2600, 4400);
    else unit_mv = unit_mv + $urandom_range(0, 300) - 150;
    if (unit_mv > 4400) unit_mv = 4400;
    if (unit_mv < 2600) unit_mv = 2600;
    tgt = unit_mv * ((cfg_cells == 0) ? 32'd1 : 32'(cfg_cells));
    bat_base = $urandom_range(400, 4000);
    ratio = 64'(bat_base) * 64'(cfg_factor) * 64'd5 / (64'd2 * 64'(tgt));
    ref_base = (cfg_factor == 0) ? 32'd2048 : ((ratio > 64'd4095) ? 32'd4095 : 32'(ratio));
    if (ref_base == 0) ref_base = 1;
    for (int i = 0; i < SET_LEN; i++) begin
      case (kind)
        SET_TRACKING: begin
          rv = int'(ref_base) + int'($urandom_range(0, 16)) - 8;
          bv = int'(bat_base) + int'($urandom_range(0, 16)) - 8;
          if ($urandom_range(0, 19) == 0) rv = $urandom_range(0, 4095);
          if ($urandom_range(0, 19) == 0) bv = $urandom_range(0, 4095);
        end
        SET_NOISE: begin
          rv = $urandom_range(0, 4095);
          bv = $urandom_range(0, 4095);
        end
        SET_ZERO_REF: begin
          rv = (i < TRIM) ? $urandom_range(0, 4095) : ($urandom_range(0, 7) == 0);
          bv = $urandom_range(0, 4095);
        end
        SET_OVERFLOW: begin
          rv = $urandom_range(1, 3);
          bv = $urandom_range(2048, 4095);
        end
        default: begin
          rv = $urandom_range(0, 1) ? 4095 : 0;
          bv = $urandom_range(0, 1) ? 4095 : 0;
        end
      endcase
      send_sample(clip12(rv), clip12(bv));
    end
  endtask

  task automatic test_register_defaults();
    logic [31:0] value;
    read_register(REG_DIVIDER, value);
    if (value !== 32'(FACTOR_RST))
      report_mismatch("divider reset value", 32'(FACTOR_RST), value);
    read_register(REG_CELLS, value);
    if (value !== 32'(CELLS_RST))
      report_mismatch("cells reset value", 32'(CELLS_RST), value);
  endtask

  task automatic test_first_set_loads_filter();
    gaps_on = 1'b0;
    send_flat_set(12'd4095, 12'd4095);
    // rails alternate: trimming keeps six of each
    for (int i = 0; i < SET_LEN; i++) send_sample(12'd4095, (i % 2) ? 12'd4095 : 12'd0);
  endtask

  task automatic test_zero_reference();
    gaps_on = 1'b1;
    for (int i = 0; i < SET_LEN; i++) send_sample((i < TRIM) ? 12'd4095 : 12'd0, 12'd4095);
  endtask

  task automatic test_voltage_overflow();
    write_register(REG_DIVIDER, 32'hFFFF_FFFF);
    send_flat_set(12'd1, 12'd4095);
  endtask

  task automatic test_cell_counts();
    write_register(REG_DIVIDER, 32'd2000);
    write_register(REG_CELLS, 32'hFFFF_FFF8);
    send_flat_set(12'd2048, 12'd1500);
    write_register(REG_CELLS, 32'd7);
    send_flat_set(12'd700, 12'd4000);
    write_register(REG_CELLS, 32'd4);
    send_flat_set(12'd1000, 12'd3000);
    write_register(REG_DIVIDER, 32'h0003_0000);
    send_flat_set(12'd2048, 12'd3000);
  endtask

  task automatic test_config_mid_set();
    write_register(REG_DIVIDER, 32'd2000);
    write_register(REG_CELLS, 32'd1);
    for (int i = 0; i < 7; i++) send_sample(12'd2000, 12'd1500);
    write_register(REG_DIVIDER, 32'h0001_1F40);
    write_register(REG_CELLS, 32'hA5A5_A5A2);
    for (int i = 7; i < SET_LEN; i++) send_sample(12'd2000, 12'd1500);
  endtask

  task automatic test_random_traffic();
    bit          in_tail;
    int unsigned pick;
    logic [15:0] factor;
    logic [2:0]  cells;
    while (items_sent < ITEM_TARGET) begin
      in_tail = (items_sent + QUIET_TAIL >= ITEM_TARGET);
      gaps_on = !in_tail && ($urandom_range(0, 3) != 0);
      if (!in_tail && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 5))
          0:       factor = 16'd0;
          1:       factor = 16'hFFFF;
          2, 3:    factor = $urandom_range(1500, 2500);
          default: factor = $urandom_range(0, 65535);
        endcase
        pick = $urandom_range(0, 11);
        cells = (pick < 8) ? 3'(pick) : 3'($urandom_range(1, 4));
        write_register(REG_DIVIDER, {16'($urandom()), factor});
        write_register(REG_CELLS, {29'($urandom()), cells});
      end
      pick = $urandom_range(0, 19);
      if (pick < 13) send_set(SET_TRACKING);
      else if (pick < 16) send_set(SET_NOISE);
      else if (pick == 16) send_set(SET_ZERO_REF);
      else if (pick == 17) send_set(SET_OVERFLOW);
      else send_set(SET_RAILS);
    end
  endtask

  always @(posedge clk_i) begin
    bvm_res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending", 32'd0, 32'(res_o.filtered_mv));
      end else begin
        want = pending_readings.pop_front();
        if (res_o.filtered_mv !== want.filtered_mv)
          report_mismatch("filtered_mv", 32'(want.filtered_mv), 32'(res_o.filtered_mv));
        if (res_o.raw_mv !== want.raw_mv)
          report_mismatch("raw_mv", 32'(want.raw_mv), 32'(res_o.raw_mv));
        if (res_o.charge_pct !== want.charge_pct)
          report_mismatch("charge_pct", 32'(want.charge_pct), 32'(res_o.charge_pct));
        if (res_o.ref_zero !== want.ref_zero)
          report_mismatch("ref_zero", 32'(want.ref_zero), 32'(res_o.ref_zero));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_first_set_loads_filter();
    test_zero_reference();
    test_voltage_overflow();
    test_cell_counts();
    test_config_mid_set();
    test_random_traffic();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
